// ----- design/aes_ctr_pkg.sv -----
// Shared types, constants and byte-level functions for the AES-256 counter-mode unit.
`default_nettype none
package aes_ctr_pkg;
	localparam int unsigned NumRounds = 14;
	localparam int unsigned NumKeyWords = 60;
	localparam logic [7:0] GfReduce = 8'h1b;
	localparam logic [7:0] GfTop = 8'h80;

	localparam logic [2:0] CFG_KEY0 = 3'd0;
	localparam logic [2:0] CFG_KEY1 = 3'd1;
	localparam logic [2:0] CFG_KEY2 = 3'd2;
	localparam logic [2:0] CFG_KEY3 = 3'd3;
	localparam logic [2:0] CFG_IV_HI = 3'd4;
	localparam logic [2:0] CFG_IV_LO = 3'd5;

	typedef logic [5:0] rk_idx_t;
	typedef logic [3:0] round_t;

	typedef struct packed {
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic [4:0] byte_count;
		logic first_block;
	} in_word_t;

	typedef struct packed {
		logic [63:0] result_hi;
		logic [63:0] result_lo;
		logic [4:0] result_count;
	} out_word_t;

	typedef struct packed {
		logic [2:0] index;
		logic [63:0] data;
	} cfg_word_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} kexp_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		logic [7:0] r;
		r = {a[6:0], 1'b0};
		if ((a & GfTop) != 8'h00) r = r ^ GfReduce;
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction
endpackage
`default_nettype wire

// ----- design/aes_ctr_if.sv -----
// Valid/ready channel interface carrying one payload word.
`default_nettype none
interface aes_ctr_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- design/aes_ctr_kexp.sv -----
// Key expansion sequencer: produces one round-key word per cycle into the key memory.
`default_nettype none
module aes_ctr_kexp (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [255:0] key,
	input wire aes_ctr_pkg::rk_idx_t rd_idx,
	output aes_ctr_pkg::kexp_ctl_t ctl,
	output logic [127:0] rd_key
);
	import aes_ctr_pkg::*;

	logic [31:0] win_q [8];
	rk_idx_t idx_q;
	logic busy_q;
	logic [7:0] rc_q;
	logic [31:0] t;
	logic [31:0] nw;

	// The last eight words sit in a window, so w[i-1] and w[i-8] are fixed taps.
	always_comb begin
		t = win_q[7];
		if (idx_q[2:0] == 3'd0) t = sub_word({win_q[7][23:0], win_q[7][31:24]}) ^ {rc_q, 24'h0};
		else if (idx_q[2:0] == 3'd4) t = sub_word(win_q[7]);
		nw = win_q[0] ^ t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			rc_q <= 8'h01;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q <= 6'd8;
			rc_q <= 8'h01;
		end else if (busy_q) begin
			if (idx_q[2:0] == 3'd0) rc_q <= xtime(rc_q);
			idx_q <= idx_q + 6'd1;
			if (idx_q == 6'(NumKeyWords - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) win_q[i] <= key[255 - 32*i -: 32];
		end else if (busy_q) begin
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
			win_q[7] <= nw;
		end
	end

	// Four words make one round key, so the memory is stored four-wide by rows.
	// The three earlier words of a row wait in the low bits of the row buffer.
	logic [127:0] rows [NumKeyWords/4];
	logic [127:0] rowbuf_q;
	always_ff @(posedge clk) begin
		if (start) begin
			rows[0] <= key[255:128];
			rows[1] <= key[127:0];
		end else if (busy_q) begin
			if (idx_q[1:0] == 2'd3) rows[idx_q[5:2]] <= {rowbuf_q[95:0], nw};
			else rowbuf_q <= {rowbuf_q[95:0], nw};
		end
		rd_key <= rows[rd_idx[5:2]];
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = busy_q && (idx_q == 6'(NumKeyWords - 1));
endmodule
`default_nettype wire

// ----- design/aes_ctr_round.sv -----
// One shared AES round unit: SubBytes, ShiftRows, optional MixColumns, key add.
`default_nettype none
module aes_ctr_round (
	input wire logic [127:0] state_in,
	input wire logic [127:0] round_key,
	input wire logic mix,
	output logic [127:0] state_out
);
	import aes_ctr_pkg::*;

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] m [16];
	logic [7:0] a0, a1, a2, a3, all;

	always_comb begin
		for (int i = 0; i < 16; i++) s[i] = state_in[127 - 8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
		for (int c = 0; c < 4; c++) begin
			a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
			all = a0 ^ a1 ^ a2 ^ a3;
			m[4*c] = mix ? (a0 ^ all ^ xtime(a0 ^ a1)) : a0;
			m[4*c+1] = mix ? (a1 ^ all ^ xtime(a1 ^ a2)) : a1;
			m[4*c+2] = mix ? (a2 ^ all ^ xtime(a2 ^ a3)) : a2;
			m[4*c+3] = mix ? (a3 ^ all ^ xtime(a3 ^ a0)) : a3;
		end
		for (int i = 0; i < 16; i++) state_out[127 - 8*i -: 8] = m[i] ^ round_key[127 - 8*i -: 8];
	end
endmodule
`default_nettype wire

// ----- design/aes256_ctr_keystream_xor_unit.sv -----
// Top level of the AES-256 counter-mode keystream unit.
// Sequence: an item with first_block 0 goes from acceptance to result valid through these steps
// (one key-row fetch, the initial key add, 14 rounds on the single round unit, output load).
// An item with first_block 1 first runs key expansion, one round-key word per cycle.
// Throughput: one item at a time; the next is accepted once the result register is free.
// Reset clears the counter, the configuration registers and all control; round keys are not.
`default_nettype none
module aes256_ctr_keystream_xor_unit (
	input wire logic clk,
	input wire logic arst_n,
	aes_ctr_if.sink in_ch,
	aes_ctr_if.source out_ch,
	aes_ctr_if.sink cfg_ch
);
	import aes_ctr_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_KEXP = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_ADD0 = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [63:0] key_q [4];
	logic [63:0] iv_hi_q, iv_lo_q;
	logic [127:0] ctr_q;
	logic [127:0] st_q;
	logic [2:0] state_q;
	round_t round_q;
	round_t rk_row;
	in_word_t item_q;
	out_word_t res_q;
	logic res_valid_q;
	logic kstart;
	kexp_ctl_t kctl;
	logic [127:0] rkey;
	logic [127:0] rnd_out;
	logic [127:0] ks;
	logic [127:0] mask;
	logic [127:0] din;
	logic in_fire;
	cfg_word_t cw;

	assign cw = cfg_ch.payload;
	assign cfg_ch.ready = 1'b1;

	// Configuration registers; a write lands on the next clock edge.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			iv_hi_q <= '0;
			iv_lo_q <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cw.index)
				CFG_KEY0: key_q[0] <= cw.data;
				CFG_KEY1: key_q[1] <= cw.data;
				CFG_KEY2: key_q[2] <= cw.data;
				CFG_KEY3: key_q[3] <= cw.data;
				CFG_IV_HI: iv_hi_q <= cw.data;
				CFG_IV_LO: iv_lo_q <= cw.data;
				default: ;
			endcase
		end
	end

	// The sequencer takes a word only when idle and the result register is empty.
	assign in_ch.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign kstart = in_fire && in_ch.payload.first_block;

	// The round-key row is read ahead of use: row 0 during the fetch, then row r+1
	// while round r runs (except the last), so each round finds its key already registered.
	always_comb begin
		rk_row = 4'd0;
		if (state_q == ST_ADD0) rk_row = 4'd1;
		else if (state_q == ST_ROUND && round_q != 4'(NumRounds)) rk_row = round_q + 4'd1;
	end

	aes_ctr_kexp u_kexp (
		.clk(clk),
		.arst_n(arst_n),
		.start(kstart),
		.key({key_q[0], key_q[1], key_q[2], key_q[3]}),
		.rd_idx(rk_idx_t'({rk_row, 2'b00})),
		.ctl(kctl),
		.rd_key(rkey)
	);

	aes_ctr_round u_round (
		.state_in(st_q),
		.round_key(rkey),
		.mix(round_q != 4'(NumRounds)),
		.state_out(rnd_out)
	);

	// Keystream for the final round, and the byte mask from the byte count.
	assign ks = rnd_out;
	always_comb begin
		for (int i = 0; i < 16; i++)
			mask[127 - 8*i -: 8] = (5'(i) < item_q.byte_count) ? 8'hff : 8'h00;
		din = {item_q.data_hi, item_q.data_lo};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			ctr_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						round_q <= '0;
						if (in_ch.payload.first_block) begin
							ctr_q <= {iv_hi_q, iv_lo_q};
							state_q <= ST_KEXP;
						end else state_q <= ST_FETCH;
					end
				end
				ST_KEXP: if (!kctl.busy) state_q <= ST_FETCH;
				ST_FETCH: state_q <= ST_ADD0;
				ST_ADD0: begin
					round_q <= 4'd1;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_q == 4'(NumRounds)) begin
						state_q <= ST_OUT;
						ctr_q <= ctr_q + 128'd1;
					end else round_q <= round_q + 4'd1;
				end
				ST_OUT: begin
					res_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Data registers: the running state, the captured input word and the result.
	always_ff @(posedge clk) begin
		if (in_fire) item_q <= in_ch.payload;
		if (state_q == ST_ADD0) st_q <= ctr_q ^ rkey;
		else if (state_q == ST_ROUND) st_q <= rnd_out;
		if (state_q == ST_ROUND && round_q == 4'(NumRounds)) begin
			{res_q.result_hi, res_q.result_lo} <= (din ^ ks) & mask;
			res_q.result_count <= item_q.byte_count;
		end
	end

	assign out_ch.valid = res_valid_q;
	assign out_ch.payload = res_q;

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ch.ready) else $error("accept while busy");
	a_out_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
	a_ctr_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> ctr_q == $past(ctr_q) + 128'd1) else $error("counter step");
`endif
endmodule
`default_nettype wire
